// ===== rtl/npe_pkg.sv =====
// Shared constants, register codes and unit handshake types of the pair energy unit.
package npe_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DIELECTRIC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF     = 2'd1;

  localparam logic [15:0] DIEL_RESET = 16'd256;
  localparam logic [15:0] Q88_ONE    = 16'd256;

  localparam logic [49:0] R2_ONE = 50'd65536;

  // 332.17752 in Q.24, scaled by 256 to divide by a Q8.8 dielectric
  localparam logic [40:0] KD_NUM   = 41'd1426691584768;
  localparam int unsigned KD_QBITS = 33;

  localparam logic [5:0] IR2_QBITS  = 6'd48;
  localparam logic [5:0] SQRT_STEPS = 6'd32;
  localparam logic [5:0] KD_STEPS   = 6'd33;

  // 2^63 pre-shifted by the number of quotient bits
  localparam logic [49:0] IR2_REM0 = 50'd32768;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef struct packed {
    logic       start;
    logic       sqrt_mode;
    logic [5:0] steps;
  } div_ctl_t;

endpackage

// ===== rtl/npe_if.sv =====
// Valid/ready channel interfaces for atom items and energy totals.
interface npe_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [15:0] charge;
  logic [31:0] coeff_a;
  logic [31:0] coeff_b;
  logic        skip_pair;
  logic        last;

  modport source (output valid, func, pos_x, pos_y, pos_z, charge, coeff_a, coeff_b,
                  skip_pair, last, input ready);
  modport sink (input valid, func, pos_x, pos_y, pos_z, charge, coeff_a, coeff_b,
                skip_pair, last, output ready);
endinterface

interface npe_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] total_energy;
  logic        saturated;

  modport source (output valid, total_energy, saturated, input ready);
  modport sink (input valid, total_energy, saturated, output ready);
endinterface

// ===== rtl/nonbonded_pair_energy_sum_unit.sv =====
// Top level: sequencer of the Coulomb plus Lennard-Jones pair energy accumulator.
//
//  channel   dir  handshake            payload
//  pair_in   in   valid/ready          func, pos_x/y/z, charge, coeff_a/b, skip_pair, last
//  sum_out   out  valid/ready          total_energy, saturated
//  cfg       in   cfg_we, no wait      cfg_index, cfg_data
//
// A group load or a flagged pair skips the arithmetic, a pair outside the cutoff stops after the
// cutoff check, and a computed pair runs the bit-per-cycle divide/root unit (48 + 32 + 33 steps)
// and the multiplier, which takes four 32 x 32 partial products per 64 x 64 product (13 products).
// Reset (synchronous, rst high) clears the sum, the group atom and the cutoff, and sets the dielectric to 1.0 (Q8.8).
// pair_in is taken only between items; a total waits in the output register while the
// next item is worked on, and a later total holds until the earlier one is taken.
module nonbonded_pair_energy_sum_unit (
  input  logic                           clk,
  input  logic                           rst,
  npe_in_if.sink                         pair_in,
  npe_out_if.source                      sum_out,
  input  logic                           cfg_we,
  input  logic [npe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [npe_pkg::CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_DIFF, ST_CUT, ST_SQ_X, ST_SQ_Y, ST_SQ_Z, ST_DIV_R, ST_MUL_IR4,
    ST_MUL_IR6, ST_MUL_IR12, ST_SQRT_IR, ST_DIV_KD, ST_MUL_Q, ST_MUL_KQ, ST_MUL_COUL,
    ST_MUL_AA, ST_MUL_VA, ST_MUL_BB, ST_MUL_VB, ST_ENERGY, ST_ACC, ST_FINISH
  } state_t;

  state_t state;

  logic [15:0]  dielectric;
  logic [15:0]  cutoff;
  logic [31:0]  group_x;
  logic [31:0]  group_y;
  logic [31:0]  group_z;
  logic [15:0]  group_charge;
  logic [31:0]  group_coeff_a;
  logic [31:0]  group_coeff_b;
  logic [63:0]  energy_sum;
  logic         sat_flag;

  logic [31:0]  p_x;
  logic [31:0]  p_y;
  logic [31:0]  p_z;
  logic [15:0]  p_charge;
  logic [31:0]  p_coeff_a;
  logic [31:0]  p_coeff_b;
  logic         last_r;

  logic [31:0]  mx;
  logic [31:0]  my;
  logic [31:0]  mz;
  logic [49:0]  r2;
  logic [47:0]  ir2;
  logic [60:0]  ir4;
  logic [60:0]  ir6;
  logic [60:0]  ir12;
  logic [30:0]  ir;
  logic [32:0]  kd;
  logic [63:0]  prod;
  logic [39:0]  cm;
  logic [55:0]  va;
  logic [55:0]  vb;
  logic [63:0]  pe;
  logic         issued;

  logic         out_valid;
  logic [63:0]  out_energy;
  logic         out_sat;

  logic                mul_start;
  logic [63:0]         mul_a;
  logic [63:0]         mul_b;
  npe_pkg::unit_stat_t mul_stat;
  logic [127:0]        mp;
  npe_pkg::div_ctl_t   div_ctl;
  logic [49:0]         div_rem0;
  logic [63:0]         div_bits;
  logic [49:0]         div_divisor;
  npe_pkg::unit_stat_t div_stat;
  logic [47:0]         dq;

  logic         is_mul;
  logic         is_div;
  logic [31:0]  ax;
  logic [31:0]  ay;
  logic [31:0]  az;
  logic [23:0]  cut_q16;
  logic         cut_fail;
  logic [15:0]  m1;
  logic [15:0]  m2;
  logic         neg;
  logic [63:0]  ve;
  logic [49:0]  r2_sum;
  logic [63:0]  acc_sum;
  logic         acc_ovf;
  logic [15:0]  diel_c;

  function automatic logic [31:0] abs_diff(input logic [31:0] g, input logic [31:0] p);
    logic [32:0] d;
    logic [32:0] m;
    d = {g[31], g} - {p[31], p};
    m = d[32] ? (33'd0 - d) : d;
    return m[31:0];
  endfunction

  function automatic logic [15:0] abs_q(input logic [15:0] v);
    return v[15] ? (16'd0 - v) : v;
  endfunction

  assign ax = abs_diff(group_x, p_x);
  assign ay = abs_diff(group_y, p_y);
  assign az = abs_diff(group_z, p_z);
  assign cut_q16 = {cutoff, 8'b0};
  assign cut_fail = (cutoff >= npe_pkg::Q88_ONE) &&
                    (({8'b0, mx} > {8'b0, cut_q16}) || ({8'b0, my} > {8'b0, cut_q16}) ||
                     ({8'b0, mz} > {8'b0, cut_q16}));
  assign m1 = abs_q(group_charge);
  assign m2 = abs_q(p_charge);
  assign neg = group_charge[15] ^ p_charge[15];
  assign ve = neg ? (64'd0 - {24'b0, cm}) : {24'b0, cm};
  assign r2_sum = r2 + {2'b0, mp[63:16]};
  assign acc_sum = energy_sum + pe;
  assign acc_ovf = (energy_sum[63] == pe[63]) && (acc_sum[63] != energy_sum[63]);
  assign diel_c = (dielectric < npe_pkg::Q88_ONE) ? npe_pkg::Q88_ONE : dielectric;

  always_comb begin
    is_mul = 1'b1;
    mul_a  = 64'b0;
    mul_b  = 64'b0;
    unique case (state)
      ST_SQ_X:     begin mul_a = {32'b0, mx};   mul_b = {32'b0, mx};   end
      ST_SQ_Y:     begin mul_a = {32'b0, my};   mul_b = {32'b0, my};   end
      ST_SQ_Z:     begin mul_a = {32'b0, mz};   mul_b = {32'b0, mz};   end
      ST_MUL_IR4:  begin mul_a = {16'b0, ir2};  mul_b = {16'b0, ir2};  end
      ST_MUL_IR6:  begin mul_a = {3'b0, ir4};   mul_b = {16'b0, ir2};  end
      ST_MUL_IR12: begin mul_a = {3'b0, ir6};   mul_b = {3'b0, ir6};   end
      ST_MUL_Q:    begin mul_a = {48'b0, m1};   mul_b = {48'b0, m2};   end
      ST_MUL_KQ:   begin mul_a = {31'b0, kd};   mul_b = prod;          end
      ST_MUL_COUL: begin mul_a = prod;          mul_b = {33'b0, ir};   end
      ST_MUL_AA:   begin mul_a = {32'b0, group_coeff_a}; mul_b = {32'b0, p_coeff_a}; end
      ST_MUL_VA:   begin mul_a = prod;          mul_b = {3'b0, ir6};   end
      ST_MUL_BB:   begin mul_a = {32'b0, group_coeff_b}; mul_b = {32'b0, p_coeff_b}; end
      ST_MUL_VB:   begin mul_a = prod;          mul_b = {3'b0, ir12};  end
      default:     is_mul = 1'b0;
    endcase
  end

  always_comb begin
    is_div      = 1'b1;
    div_rem0    = 50'b0;
    div_bits    = 64'b0;
    div_divisor = 50'b0;
    div_ctl.sqrt_mode = 1'b0;
    div_ctl.steps     = npe_pkg::IR2_QBITS;
    unique case (state)
      ST_DIV_R: begin
        div_rem0    = npe_pkg::IR2_REM0;
        div_divisor = r2;
      end
      ST_SQRT_IR: begin
        div_bits          = {3'b0, ir2, 13'b0};
        div_ctl.sqrt_mode = 1'b1;
        div_ctl.steps     = npe_pkg::SQRT_STEPS;
      end
      ST_DIV_KD: begin
        div_rem0      = 50'(npe_pkg::KD_NUM >> npe_pkg::KD_QBITS);
        div_bits      = {npe_pkg::KD_NUM[32:0], 31'b0};
        div_divisor   = {34'b0, diel_c};
        div_ctl.steps = npe_pkg::KD_STEPS;
      end
      default: is_div = 1'b0;
    endcase
    div_ctl.start = is_div && !issued;
  end

  assign mul_start     = is_mul && !issued;

  npe_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .stat  (mul_stat),
    .p     (mp)
  );

  npe_div u_div (
    .clk     (clk),
    .rst     (rst),
    .ctl     (div_ctl),
    .rem0    (div_rem0),
    .bits    (div_bits),
    .divisor (div_divisor),
    .stat    (div_stat),
    .q       (dq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      issued        <= 1'b0;
      dielectric    <= npe_pkg::DIEL_RESET;
      cutoff        <= 16'd0;
      group_x       <= 32'd0;
      group_y       <= 32'd0;
      group_z       <= 32'd0;
      group_charge  <= 16'd0;
      group_coeff_a <= 32'd0;
      group_coeff_b <= 32'd0;
      energy_sum    <= 64'd0;
      sat_flag      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == npe_pkg::REG_DIELECTRIC) begin
          dielectric <= cfg_data;
        end else if (cfg_index == npe_pkg::REG_CUTOFF) begin
          cutoff <= cfg_data;
        end
      end
      if (out_valid && sum_out.ready && !(state == ST_FINISH && last_r)) begin
        out_valid <= 1'b0;
      end
      if (mul_start || div_ctl.start) begin
        issued <= 1'b1;
      end
      if (mul_stat.done || div_stat.done) begin
        issued <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pair_in.valid) begin
            p_x       <= pair_in.pos_x;
            p_y       <= pair_in.pos_y;
            p_z       <= pair_in.pos_z;
            p_charge  <= pair_in.charge;
            p_coeff_a <= pair_in.coeff_a;
            p_coeff_b <= pair_in.coeff_b;
            last_r    <= pair_in.last;
            if (!pair_in.func) begin
              group_x       <= pair_in.pos_x;
              group_y       <= pair_in.pos_y;
              group_z       <= pair_in.pos_z;
              group_charge  <= pair_in.charge;
              group_coeff_a <= pair_in.coeff_a;
              group_coeff_b <= pair_in.coeff_b;
              state         <= ST_FINISH;
            end else if (pair_in.skip_pair) begin
              state <= ST_FINISH;
            end else begin
              state <= ST_DIFF;
            end
          end
        end
        ST_DIFF: begin
          mx    <= ax;
          my    <= ay;
          mz    <= az;
          state <= ST_CUT;
        end
        ST_CUT:      state <= cut_fail ? ST_FINISH : ST_SQ_X;
        ST_SQ_X: if (mul_stat.done) begin
          r2    <= {2'b0, mp[63:16]};
          state <= ST_SQ_Y;
        end
        ST_SQ_Y: if (mul_stat.done) begin
          r2    <= r2_sum;
          state <= ST_SQ_Z;
        end
        ST_SQ_Z: if (mul_stat.done) begin
          r2    <= (r2_sum < npe_pkg::R2_ONE) ? npe_pkg::R2_ONE : r2_sum;
          state <= ST_DIV_R;
        end
        ST_DIV_R: if (div_stat.done) begin
          ir2   <= dq;
          state <= ST_MUL_IR4;
        end
        ST_MUL_IR4: if (mul_stat.done) begin
          ir4   <= mp[94:34];
          state <= ST_MUL_IR6;
        end
        ST_MUL_IR6: if (mul_stat.done) begin
          ir6   <= mp[107:47];
          state <= ST_MUL_IR12;
        end
        ST_MUL_IR12: if (mul_stat.done) begin
          ir12  <= mp[120:60];
          state <= ST_SQRT_IR;
        end
        ST_SQRT_IR: if (div_stat.done) begin
          ir    <= dq[30:0];
          state <= ST_DIV_KD;
        end
        ST_DIV_KD: if (div_stat.done) begin
          kd    <= dq[32:0];
          state <= ST_MUL_Q;
        end
        ST_MUL_Q: if (mul_stat.done) begin
          prod  <= mp[63:0];
          state <= ST_MUL_KQ;
        end
        ST_MUL_KQ: if (mul_stat.done) begin
          prod  <= mp[63:0];
          state <= ST_MUL_COUL;
        end
        ST_MUL_COUL: if (mul_stat.done) begin
          cm    <= mp[93:54];
          state <= ST_MUL_AA;
        end
        ST_MUL_AA: if (mul_stat.done) begin
          prod  <= mp[63:0];
          state <= ST_MUL_VA;
        end
        ST_MUL_VA: if (mul_stat.done) begin
          va    <= mp[123:68];
          state <= ST_MUL_BB;
        end
        ST_MUL_BB: if (mul_stat.done) begin
          prod  <= mp[63:0];
          state <= ST_MUL_VB;
        end
        ST_MUL_VB: if (mul_stat.done) begin
          vb    <= mp[123:68];
          state <= ST_ENERGY;
        end
        ST_ENERGY: begin
          pe    <= ve - {8'b0, va} + {8'b0, vb};
          state <= ST_ACC;
        end
        ST_ACC: begin
          if (acc_ovf) begin
            energy_sum <= energy_sum[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
            sat_flag   <= 1'b1;
          end else begin
            energy_sum <= acc_sum;
          end
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!last_r) begin
            state <= ST_IDLE;
          end else if (!out_valid || sum_out.ready) begin
            out_valid  <= 1'b1;
            out_energy <= energy_sum;
            out_sat    <= sat_flag;
            energy_sum <= 64'd0;
            sat_flag   <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign pair_in.ready        = (state == ST_IDLE);
  assign sum_out.valid        = out_valid;
  assign sum_out.total_energy = out_energy;
  assign sum_out.saturated    = out_sat;

`ifndef ASSERT_OFF
  a_mul_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_stat.busy)
    else $error("multiplier started while busy");

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    div_ctl.start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_r2_clamped: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_R) |-> (r2 >= npe_pkg::R2_ONE))
    else $error("distance squared below one at divide");

  a_root_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_KD) |-> (ir <= 31'h40000000))
    else $error("inverse distance out of range");

  a_total_on_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> ($past(state) == ST_FINISH && $past(last_r)))
    else $error("total emitted without last item");
`endif

endmodule

// ===== rtl/npe_mul.sv =====
// Iterative 64 x 64 multiplier built from one 32 x 32 multiplier and a product accumulator.
module npe_mul (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [63:0]          a,
  input  logic [63:0]          b,
  output npe_pkg::unit_stat_t  stat,
  output logic [127:0]         p
);

  logic [2:0]   cnt;
  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [63:0]  pp;
  logic [1:0]   pcode;
  logic         pv;
  logic [127:0] acc;
  logic         busy;
  logic         done;
  logic [31:0]  a_part;
  logic [31:0]  b_part;
  logic [63:0]  pp_now;
  logic [127:0] pp_sh;
  logic [1:0]   pcode_now;

  assign a_part = cnt[1] ? a_r[63:32] : a_r[31:0];
  assign b_part = cnt[0] ? b_r[63:32] : b_r[31:0];
  assign pp_now = {32'b0, a_part} * {32'b0, b_part};
  assign pcode_now = (cnt == 3'd0) ? 2'd0 : ((cnt == 3'd3) ? 2'd2 : 2'd1);

  always_comb begin
    unique case (pcode)
      2'd0:    pp_sh = {64'b0, pp};
      2'd1:    pp_sh = {32'b0, pp, 32'b0};
      default: pp_sh = {pp, 64'b0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      pv   <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_r  <= a;
        b_r  <= b;
        acc  <= 128'b0;
        cnt  <= 3'd0;
        pv   <= 1'b0;
        busy <= 1'b1;
      end else if (busy) begin
        if (cnt != 3'd4) begin
          pp    <= pp_now;
          pcode <= pcode_now;
          pv    <= 1'b1;
          cnt   <= cnt + 3'd1;
        end else begin
          pv <= 1'b0;
        end
        if (pv) begin
          acc <= acc + pp_sh;
        end
        if (cnt == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign p = acc;

endmodule

// ===== rtl/npe_div.sv =====
// Bit-serial restoring divider and digit-by-digit square root on one subtract-compare unit.
module npe_div (
  input  logic                 clk,
  input  logic                 rst,
  input  npe_pkg::div_ctl_t    ctl,
  input  logic [49:0]          rem0,
  input  logic [63:0]          bits,
  input  logic [49:0]          divisor,
  output npe_pkg::unit_stat_t  stat,
  output logic [47:0]          q
);

  logic [49:0] rem;
  logic [63:0] bits_r;
  logic [49:0] div_r;
  logic [47:0] q_r;
  logic [5:0]  cnt;
  logic        mode;
  logic        busy;
  logic        done;
  logic [51:0] cand;
  logic [51:0] sub;
  logic [51:0] diff;
  logic        ge;
  logic [49:0] rem_next;

  assign cand = mode ? {rem, bits_r[63:62]} : {1'b0, rem, bits_r[63]};
  assign sub  = mode ? {2'b0, q_r, 2'b01} : {2'b0, div_r};
  assign ge   = (cand >= sub);
  assign diff = cand - sub;
  assign rem_next = ge ? diff[49:0] : cand[49:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        rem    <= rem0;
        bits_r <= bits;
        div_r  <= divisor;
        q_r    <= 48'b0;
        cnt    <= ctl.steps;
        mode   <= ctl.sqrt_mode;
        busy   <= 1'b1;
      end else if (busy) begin
        rem    <= rem_next;
        q_r    <= {q_r[46:0], ge};
        bits_r <= mode ? {bits_r[61:0], 2'b0} : {bits_r[62:0], 1'b0};
        cnt    <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign q = q_r;

endmodule

// ===== verif/tb_top.sv =====
// Testbench for the nonbonded pair energy unit: random and directed atom items, checked per total.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [npe_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd2;
  localparam logic [63:0] COUL_Q24 = 64'd5573014003;
  localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;
  localparam int DRAIN_CYCLES = 400;
  localparam int LONG_HOLD = 3000;

  typedef struct {
    logic        func;
    logic [31:0] px, py, pz;
    logic [15:0] q;
    logic [31:0] ca, cb;
    logic        skip, last;
  } atom_t;

  typedef struct {
    logic [63:0] energy;
    logic        sat;
  } total_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [npe_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [npe_pkg::CFG_DATA_W-1:0] cfg_data;

  npe_in_if pair_in ();
  npe_out_if sum_out ();

  nonbonded_pair_energy_sum_unit dut (
    .clk(clk), .rst(rst), .pair_in(pair_in), .sum_out(sum_out),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [31:0] grp_x, grp_y, grp_z, grp_ca, grp_cb;
  logic [15:0] grp_q;
  logic [63:0] sum_acc;
  logic        sum_sat;
  logic [15:0] diel_reg, cut_reg;

  total_t totals_due[$];
  int errors = 0;
  bit quiet = 1'b0;
  int hold_req = 0;

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> s;
    if (p[127:64] != 0) return '1;
    return p[63:0];
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] axis_mag(logic [31:0] g, logic [31:0] p);
    logic [32:0] d;
    d = {g[31], g} - {p[31], p};
    if (d[32]) d = -d;
    return {31'd0, d};
  endfunction

  function automatic logic [63:0] pair_energy(atom_t a);
    logic [63:0] mx, my, mz, r2, ir2, ir4, ir6, ir12, ir, diel, kd;
    logic [63:0] m1, m2, cm, ve, va, vb;
    mx = axis_mag(grp_x, a.px);
    my = axis_mag(grp_y, a.py);
    mz = axis_mag(grp_z, a.pz);
    r2 = ((mx * mx) >> 16) + ((my * my) >> 16) + ((mz * mz) >> 16);
    if (r2 < 64'd65536) r2 = 64'd65536;
    ir2 = SIGN64 / r2;
    ir4 = mul_shr(ir2, ir2, 34);
    ir6 = mul_shr(ir4, ir2, 47);
    ir12 = mul_shr(ir6, ir6, 60);
    ir = isqrt(ir2 << 13);
    diel = (diel_reg < 16'd256) ? 64'd256 : {48'd0, diel_reg};
    kd = (COUL_Q24 * 64'd256) / diel;
    m1 = grp_q[15] ? 64'(-$signed({48'hFFFF_FFFF_FFFF, grp_q})) : {48'd0, grp_q};
    m2 = a.q[15] ? 64'(-$signed({48'hFFFF_FFFF_FFFF, a.q})) : {48'd0, a.q};
    cm = mul_shr(kd * (m1 * m2), ir, 54);
    ve = (grp_q[15] ^ a.q[15]) ? -cm : cm;
    va = mul_shr({32'd0, grp_ca} * {32'd0, a.ca}, ir6, 68);
    vb = mul_shr({32'd0, grp_cb} * {32'd0, a.cb}, ir12, 68);
    return ve - va + vb;
  endfunction

  task automatic predict_atom(atom_t a);
    logic [63:0] p, r, cut;
    logic keep;
    if (!a.func) begin
      grp_x = a.px; grp_y = a.py; grp_z = a.pz;
      grp_q = a.q; grp_ca = a.ca; grp_cb = a.cb;
    end else if (!a.skip) begin
      keep = 1'b1;
      if (cut_reg >= 16'd256) begin
        cut = {40'd0, cut_reg, 8'd0};
        if (axis_mag(grp_x, a.px) > cut || axis_mag(grp_y, a.py) > cut ||
            axis_mag(grp_z, a.pz) > cut) keep = 1'b0;
      end
      if (keep) begin
        p = pair_energy(a);
        r = sum_acc + p;
        if (((sum_acc ^ p) & SIGN64) == 0 && ((r ^ sum_acc) & SIGN64) != 0) begin
          r = sum_acc[63] ? SIGN64 : SIGN64 - 1;
          sum_sat = 1'b1;
        end
        sum_acc = r;
      end
    end
    if (a.last) begin
      totals_due.push_back('{energy: sum_acc, sat: sum_sat});
      sum_acc = 0;
      sum_sat = 1'b0;
    end
  endtask

  function automatic int pick_gap();
    if (quiet) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(20, 60);
    return $urandom_range(0, 3);
  endfunction

  task automatic send_atom(atom_t a);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pair_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pair_in.valid <= 1'b1;
    pair_in.func <= a.func;
    pair_in.pos_x <= a.px;
    pair_in.pos_y <= a.py;
    pair_in.pos_z <= a.pz;
    pair_in.charge <= a.q;
    pair_in.coeff_a <= a.ca;
    pair_in.coeff_b <= a.cb;
    pair_in.skip_pair <= a.skip;
    pair_in.last <= a.last;
    @(posedge clk);
    while (!pair_in.ready) @(posedge clk);
    predict_atom(a);
  endtask

  task automatic drain();
    pair_in.valid <= 1'b0;
    @(posedge clk);
    while (totals_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [npe_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == npe_pkg::REG_DIELECTRIC) diel_reg = val;
    else if (idx == npe_pkg::REG_CUTOFF) cut_reg = val;
  endtask

  function automatic atom_t mk(logic func, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                               logic [15:0] q, logic [31:0] ca, logic [31:0] cb,
                               logic skip, logic last);
    atom_t a;
    a.func = func; a.px = x; a.py = y; a.pz = z; a.q = q;
    a.ca = ca; a.cb = cb; a.skip = skip; a.last = last;
    return a;
  endfunction

  function automatic logic [31:0] rnd_coeff();
    case ($urandom_range(0, 5))
      0: return 32'hFFFF_FFFF;
      1: return 32'd0;
      2, 3: return $urandom;
      default: return $urandom_range(0, 32'h0010_0000);
    endcase
  endfunction

  function automatic logic [31:0] near(logic [31:0] c);
    return c + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
  endfunction

  function automatic atom_t rnd_atom();
    atom_t a;
    a.func = ($urandom_range(0, 7) == 0) ? 1'b0 : 1'b1;
    if ($urandom_range(0, 3) == 0) begin
      a.px = $urandom; a.py = $urandom; a.pz = $urandom;
    end else if (!a.func) begin
      a.px = $urandom_range(0, 32'h0064_0000) - 32'h0032_0000;
      a.py = $urandom_range(0, 32'h0064_0000) - 32'h0032_0000;
      a.pz = $urandom_range(0, 32'h0064_0000) - 32'h0032_0000;
    end else begin
      a.px = near(grp_x); a.py = near(grp_y); a.pz = near(grp_z);
    end
    a.q = 16'($urandom);
    a.ca = rnd_coeff();
    a.cb = rnd_coeff();
    a.skip = ($urandom_range(0, 9) == 0);
    a.last = ($urandom_range(0, 7) == 0);
    return a;
  endfunction

  task automatic test_directed();
    // partner before any group atom pairs with the all-zero atom
    send_atom(mk(1, 32'h0001_0000, 0, 0, 16'h1000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1));
    send_atom(mk(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0));
    send_atom(mk(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1));
    send_atom(mk(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF,
                 32'h0000_0001, 32'h0000_0001, 0, 0));
    send_atom(mk(1, 32'h7FFF_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8000, 0, 0, 1, 1));
    send_atom(mk(0, 0, 0, 0, 16'h8000, 32'h0002_0000, 32'h0003_0000, 0, 0));
    send_atom(mk(1, 32'h0000_8000, 0, 0, 16'h8000, 32'h0002_0000, 32'h0003_0000, 0, 0));
    send_atom(mk(1, 32'h0003_0000, 32'hFFFE_0000, 32'h0001_8000, 16'h7FFF, 0, 0, 0, 0));
    send_atom(mk(1, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 16'h0000,
                 32'h0000_FFFF, 32'hFFFF_0000, 0, 1));
    // load and emit on the same item
    send_atom(mk(0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 16'h0800,
                 32'h0001_0000, 32'h0001_0000, 1, 1));
    send_atom(mk(1, 32'h0005_0000, 32'h0001_0000, 32'h0001_0000, 16'hF800,
                 32'h0001_0000, 32'h0001_0000, 0, 1));
  endtask

  task automatic test_cutoff();
    write_reg(npe_pkg::REG_CUTOFF, 16'h0200);
    send_atom(mk(0, 0, 0, 0, 16'h1000, 32'h0001_0000, 32'h0001_0000, 0, 0));
    send_atom(mk(1, 32'h0002_0000, 0, 0, 16'h1000, 32'h0001_0000, 32'h0001_0000, 0, 0));
    send_atom(mk(1, 0, 32'hFFFE_0000, 0, 16'h1000, 32'h0001_0000, 32'h0001_0000, 0, 0));
    send_atom(mk(1, 0, 0, 32'h0002_0001, 16'h1000, 32'h0001_0000, 32'h0001_0000, 0, 0));
    send_atom(mk(1, 32'hFFFD_FFFF, 0, 0, 16'h1000, 32'h0001_0000, 32'h0001_0000, 0, 1));
    write_reg(npe_pkg::REG_CUTOFF, 16'h00FF);
    send_atom(mk(1, 32'h0040_0000, 0, 0, 16'h1000, 32'h0001_0000, 32'h0001_0000, 0, 1));
    write_reg(npe_pkg::REG_CUTOFF, 16'hFFFF);
    send_atom(mk(1, 32'h7FFF_FFFF, 32'h0100_0000, 0, 16'h1000, 32'h0001_0000, 0, 0, 1));
    write_reg(REG_SPARE, 16'h0000);
    write_reg(npe_pkg::REG_CUTOFF, 16'h0000);
  endtask

  task automatic test_dielectric();
    logic [15:0] diels[4] = '{16'h0000, 16'h00FF, 16'hFFFF, 16'h0100};
    foreach (diels[i]) begin
      write_reg(npe_pkg::REG_DIELECTRIC, diels[i]);
      send_atom(mk(0, 0, 0, 0, 16'h7FFF, 0, 0, 0, 0));
      send_atom(mk(1, 32'h0000_4000, 0, 0, 16'h7FFF, 0, 0, 0, 0));
      send_atom(mk(1, 32'h0003_0000, 0, 0, 16'h8000, 0, 0, 0, 1));
    end
  endtask

  task automatic test_saturation(bit up);
    send_atom(mk(0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0));
    repeat (140)
      send_atom(mk(1, 0, 0, 0, 0, up ? 32'd0 : 32'hFFFF_FFFF, up ? 32'hFFFF_FFFF : 32'd0, 0, 0));
    send_atom(mk(1, 32'h0010_0000, 0, 0, 16'h4000, 0, 0, 0, 1));
  endtask

  task automatic test_backpressure();
    hold_req++;
    quiet = 1'b1;
    repeat (20)
      send_atom(mk(0, $urandom, $urandom, $urandom, 16'($urandom), $urandom, $urandom, 0, 1));
    quiet = 1'b0;
    drain();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 250 == 249) begin
        write_reg(npe_pkg::REG_DIELECTRIC, 16'($urandom));
        write_reg(npe_pkg::REG_CUTOFF,
                  ($urandom_range(0, 1) != 0) ? 16'h0000 : 16'($urandom_range(256, 2048)));
      end
      if (i % 300 == 150) drain();
      quiet = (i % 200) >= 170;
      send_atom(rnd_atom());
    end
    quiet = 1'b0;
    send_atom(mk(1, $urandom, $urandom, $urandom, 16'($urandom), $urandom, $urandom, 0, 1));
  endtask

  // result side
  int stall_left = 0;
  int hold_seen = 0;

  always @(posedge clk) begin
    if (rst) begin
      sum_out.ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      stall_left = LONG_HOLD;
      sum_out.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      sum_out.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
      sum_out.ready <= 1'b0;
    end else begin
      sum_out.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    total_t want;
    if (!rst && sum_out.valid && sum_out.ready) begin
      if (totals_due.size() == 0) begin
        report("unexpected total", sum_out.total_energy, 64'd0);
      end else begin
        want = totals_due.pop_front();
        if (sum_out.total_energy !== want.energy)
          report("total_energy", sum_out.total_energy, want.energy);
        if (sum_out.saturated !== want.sat)
          report("saturated", {63'd0, sum_out.saturated}, {63'd0, want.sat});
      end
    end
  end

  initial begin
    pair_in.valid = 1'b0;
    pair_in.func = 1'b0;
    pair_in.pos_x = '0;
    pair_in.pos_y = '0;
    pair_in.pos_z = '0;
    pair_in.charge = '0;
    pair_in.coeff_a = '0;
    pair_in.coeff_b = '0;
    pair_in.skip_pair = 1'b0;
    pair_in.last = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    grp_x = 0; grp_y = 0; grp_z = 0; grp_q = 0; grp_ca = 0; grp_cb = 0;
    sum_acc = 0; sum_sat = 1'b0;
    diel_reg = npe_pkg::DIEL_RESET;
    cut_reg = 16'd0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_cutoff();
    test_dielectric();
    test_saturation(1'b1);
    test_saturation(1'b0);
    test_backpressure();
    test_random(720);
    drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
